### rtl/core/dstq_pkg.sv
// Shared types, codes and constants of the deadline-sorted timer queue.
package dstq_pkg;

    localparam int NUM_IDS             = 16;
    localparam int ID_W                = 4;
    localparam int DEADLINE_W          = 64;
    localparam int TIMEOUT_W           = 32;
    localparam int DEFAULT_QUEUE_DEPTH = 16;

    // Operation codes of an input beat.
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    // Result kinds.
    localparam logic [2:0] KIND_ADDED     = 3'd0;
    localparam logic [2:0] KIND_REMOVED   = 3'd1;
    localparam logic [2:0] KIND_NOT_FOUND = 3'd2;
    localparam logic [2:0] KIND_FULL      = 3'd3;
    localparam logic [2:0] KIND_EXPIRED   = 3'd4;
    localparam logic [2:0] KIND_NOTHING   = 3'd5;

    typedef struct packed {
        logic [1:0]            op;
        logic [DEADLINE_W-1:0] now_time;
        logic [TIMEOUT_W-1:0]  timeout;
        logic [ID_W-1:0]       target_id;
    } in_t;

    typedef struct packed {
        logic [2:0]            kind;
        logic [ID_W-1:0]       result_id;
        logic [DEADLINE_W-1:0] result_deadline;
        logic                  last;
    } out_t;

    // One table slot: deadline plus owning id.
    typedef struct packed {
        logic [DEADLINE_W-1:0] deadline;
        logic [ID_W-1:0]       id;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_ADD_RD,
        ST_ADD_CMP,
        ST_REM_RD,
        ST_REM_CMP,
        ST_TICK_RD,
        ST_TICK_CMP,
        ST_SH_RD,
        ST_SH_WR
    } state_t;

    typedef enum logic [3:0] {
        CMD_NOP,
        CMD_LOAD,
        CMD_FULL,
        CMD_ADD_RD,
        CMD_ADD_SHIFT,
        CMD_ADD_PUT,
        CMD_RD,
        CMD_IDX_INC,
        CMD_NOT_FOUND,
        CMD_REM_HIT,
        CMD_TICK_TAKE,
        CMD_TICK_END,
        CMD_SH_WR,
        CMD_SH_DONE
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       full;
        logic       idx_zero;
        logic       idx_at_count;
        logic       later;
        logic       expired;
        logic       id_match;
        logic       pend_valid;
    } status_t;

endpackage

### rtl/core/dstq_ctrl.sv
// Sequencing state machine of the timer queue: walks the table for each add that fits, each remove and each tick.
module dstq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  dstq_pkg::status_t status,
    output dstq_pkg::cmd_t    cmd,
    output logic              busy
);

    dstq_pkg::state_t state_reg;
    dstq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dstq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = dstq_pkg::CMD_NOP;
        busy       = (state_reg != dstq_pkg::ST_IDLE);
        case (state_reg)
            dstq_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd        = dstq_pkg::CMD_LOAD;
                    state_next = dstq_pkg::ST_DISPATCH;
                end
            end
            dstq_pkg::ST_DISPATCH:
            begin
                case (status.op)
                    dstq_pkg::OP_ADD:
                    begin
                        if (status.full)
                        begin
                            cmd        = dstq_pkg::CMD_FULL;
                            state_next = dstq_pkg::ST_IDLE;
                        end
                        else
                        begin
                            state_next = dstq_pkg::ST_ADD_RD;
                        end
                    end
                    dstq_pkg::OP_REMOVE: state_next = dstq_pkg::ST_REM_RD;
                    dstq_pkg::OP_TICK:   state_next = dstq_pkg::ST_TICK_RD;
                    default:             state_next = dstq_pkg::ST_IDLE;
                endcase
            end
            dstq_pkg::ST_ADD_RD:
            begin
                // Reached the head: the new timer goes in slot zero.
                if (status.idx_zero)
                begin
                    cmd        = dstq_pkg::CMD_ADD_PUT;
                    state_next = dstq_pkg::ST_IDLE;
                end
                else
                begin
                    cmd        = dstq_pkg::CMD_ADD_RD;
                    state_next = dstq_pkg::ST_ADD_CMP;
                end
            end
            dstq_pkg::ST_ADD_CMP:
            begin
                if (status.later)
                begin
                    cmd        = dstq_pkg::CMD_ADD_SHIFT;
                    state_next = dstq_pkg::ST_ADD_RD;
                end
                else
                begin
                    cmd        = dstq_pkg::CMD_ADD_PUT;
                    state_next = dstq_pkg::ST_IDLE;
                end
            end
            dstq_pkg::ST_REM_RD:
            begin
                if (status.idx_at_count)
                begin
                    cmd        = dstq_pkg::CMD_NOT_FOUND;
                    state_next = dstq_pkg::ST_IDLE;
                end
                else
                begin
                    cmd        = dstq_pkg::CMD_RD;
                    state_next = dstq_pkg::ST_REM_CMP;
                end
            end
            dstq_pkg::ST_REM_CMP:
            begin
                if (status.id_match)
                begin
                    cmd        = dstq_pkg::CMD_REM_HIT;
                    state_next = dstq_pkg::ST_SH_RD;
                end
                else
                begin
                    cmd        = dstq_pkg::CMD_IDX_INC;
                    state_next = dstq_pkg::ST_REM_RD;
                end
            end
            dstq_pkg::ST_TICK_RD:
            begin
                if (status.idx_at_count)
                begin
                    cmd        = dstq_pkg::CMD_TICK_END;
                    state_next = status.pend_valid ? dstq_pkg::ST_SH_RD : dstq_pkg::ST_IDLE;
                end
                else
                begin
                    cmd        = dstq_pkg::CMD_RD;
                    state_next = dstq_pkg::ST_TICK_CMP;
                end
            end
            dstq_pkg::ST_TICK_CMP:
            begin
                if (status.expired)
                begin
                    cmd        = dstq_pkg::CMD_TICK_TAKE;
                    state_next = dstq_pkg::ST_TICK_RD;
                end
                else
                begin
                    cmd        = dstq_pkg::CMD_TICK_END;
                    state_next = status.pend_valid ? dstq_pkg::ST_SH_RD : dstq_pkg::ST_IDLE;
                end
            end
            dstq_pkg::ST_SH_RD:
            begin
                if (status.idx_at_count)
                begin
                    cmd        = dstq_pkg::CMD_SH_DONE;
                    state_next = dstq_pkg::ST_IDLE;
                end
                else
                begin
                    cmd        = dstq_pkg::CMD_RD;
                    state_next = dstq_pkg::ST_SH_WR;
                end
            end
            dstq_pkg::ST_SH_WR:
            begin
                cmd        = dstq_pkg::CMD_SH_WR;
                state_next = dstq_pkg::ST_SH_RD;
            end
            default:
            begin
                state_next = dstq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/dstq_datapath.sv
// Table memory, pointers, id map and result register of the timer queue.
module dstq_datapath #(
    parameter int QUEUE_DEPTH = dstq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  dstq_pkg::in_t     item,
    input  dstq_pkg::cmd_t    cmd,
    output dstq_pkg::status_t status,
    output dstq_pkg::out_t    result,
    output logic              result_strobe
);

    localparam int CAP = (QUEUE_DEPTH < dstq_pkg::NUM_IDS) ? QUEUE_DEPTH : dstq_pkg::NUM_IDS;
    localparam int AW  = $clog2(CAP);
    localparam int CW  = $clog2(CAP + 1);
    localparam int DW  = dstq_pkg::DEADLINE_W;
    localparam int IW  = dstq_pkg::ID_W;

    // Table memory
    dstq_pkg::entry_t mem [CAP];
    dstq_pkg::entry_t rd_q;
    logic             mem_we;
    logic             mem_re;
    logic [AW-1:0]    mem_waddr;
    logic [AW-1:0]    mem_raddr;
    dstq_pkg::entry_t mem_wdata;

    // Control state
    logic [CW-1:0]              count_reg, count_next;
    logic [dstq_pkg::NUM_IDS-1:0] map_reg, map_next;
    logic [CW-1:0]              idx_reg, idx_next;
    logic [CW-1:0]              wr_reg, wr_next;
    logic                       pend_valid_reg, pend_valid_next;
    logic                       strobe_reg, strobe_next;

    // Payload
    dstq_pkg::in_t    in_reg, in_next;
    logic [DW-1:0]    dl_reg, dl_next;
    logic [IW-1:0]    new_id_reg, new_id_next;
    dstq_pkg::entry_t pend_reg, pend_next;
    dstq_pkg::out_t   res_reg, res_next;

    logic [DW:0]      sum;
    logic [IW-1:0]    lowest_free;
    logic [CW-1:0]    idx_m1;

    assign sum    = {1'b0, item.now_time} + {{(DW + 1 - dstq_pkg::TIMEOUT_W){1'b0}}, item.timeout};
    assign idx_m1 = idx_reg - CW'(1);

    always_comb
    begin
        lowest_free = '0;
        for (int i = dstq_pkg::NUM_IDS - 1; i >= 0; i--)
        begin
            if (map_reg[i])
            begin
                lowest_free = IW'(i);
            end
        end
    end

    assign status.op           = in_reg.op;
    assign status.full         = (count_reg >= CW'(CAP)) || (map_reg == '0);
    assign status.idx_zero     = (idx_reg == '0);
    assign status.idx_at_count = (idx_reg == count_reg);
    assign status.later        = (rd_q.deadline > dl_reg);
    assign status.expired      = (rd_q.deadline <= in_reg.now_time);
    assign status.id_match     = (rd_q.id == in_reg.target_id);
    assign status.pend_valid   = pend_valid_reg;

    always_comb
    begin
        count_next      = count_reg;
        map_next        = map_reg;
        idx_next        = idx_reg;
        wr_next         = wr_reg;
        pend_valid_next = pend_valid_reg;
        strobe_next     = 1'b0;
        in_next         = in_reg;
        dl_next         = dl_reg;
        new_id_next     = new_id_reg;
        pend_next       = pend_reg;
        res_next        = res_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = idx_reg[AW-1:0];
        mem_raddr       = idx_reg[AW-1:0];
        mem_wdata       = rd_q;
        case (cmd)
            dstq_pkg::CMD_LOAD:
            begin
                in_next         = item;
                dl_next         = sum[DW] ? {DW{1'b1}} : sum[DW-1:0];
                new_id_next     = lowest_free;
                idx_next        = (item.op == dstq_pkg::OP_ADD) ? count_reg : '0;
                pend_valid_next = 1'b0;
            end
            dstq_pkg::CMD_FULL:
            begin
                strobe_next              = 1'b1;
                res_next.kind            = dstq_pkg::KIND_FULL;
                res_next.result_id       = '0;
                res_next.result_deadline = '0;
                res_next.last            = 1'b1;
            end
            dstq_pkg::CMD_ADD_RD:
            begin
                mem_re    = 1'b1;
                mem_raddr = idx_m1[AW-1:0];
            end
            dstq_pkg::CMD_ADD_SHIFT:
            begin
                // Move the later entry up one slot.
                mem_we   = 1'b1;
                idx_next = idx_m1;
            end
            dstq_pkg::CMD_ADD_PUT:
            begin
                mem_we                   = 1'b1;
                mem_wdata.deadline       = dl_reg;
                mem_wdata.id             = new_id_reg;
                count_next               = count_reg + CW'(1);
                map_next                 = map_reg & ~(dstq_pkg::NUM_IDS'(1) << new_id_reg);
                strobe_next              = 1'b1;
                res_next.kind            = dstq_pkg::KIND_ADDED;
                res_next.result_id       = new_id_reg;
                res_next.result_deadline = dl_reg;
                res_next.last            = 1'b1;
            end
            dstq_pkg::CMD_RD:
            begin
                mem_re = 1'b1;
            end
            dstq_pkg::CMD_IDX_INC:
            begin
                idx_next = idx_reg + CW'(1);
            end
            dstq_pkg::CMD_NOT_FOUND:
            begin
                strobe_next              = 1'b1;
                res_next.kind            = dstq_pkg::KIND_NOT_FOUND;
                res_next.result_id       = in_reg.target_id;
                res_next.result_deadline = '0;
                res_next.last            = 1'b1;
            end
            dstq_pkg::CMD_REM_HIT:
            begin
                map_next                 = map_reg | (dstq_pkg::NUM_IDS'(1) << rd_q.id);
                wr_next                  = idx_reg;
                idx_next                 = idx_reg + CW'(1);
                strobe_next              = 1'b1;
                res_next.kind            = dstq_pkg::KIND_REMOVED;
                res_next.result_id       = rd_q.id;
                res_next.result_deadline = '0;
                res_next.last            = 1'b1;
            end
            dstq_pkg::CMD_TICK_TAKE:
            begin
                // Release the held entry now that another one follows it.
                if (pend_valid_reg)
                begin
                    strobe_next              = 1'b1;
                    res_next.kind            = dstq_pkg::KIND_EXPIRED;
                    res_next.result_id       = pend_reg.id;
                    res_next.result_deadline = pend_reg.deadline;
                    res_next.last            = 1'b0;
                end
                pend_next       = rd_q;
                pend_valid_next = 1'b1;
                map_next        = map_reg | (dstq_pkg::NUM_IDS'(1) << rd_q.id);
                idx_next        = idx_reg + CW'(1);
            end
            dstq_pkg::CMD_TICK_END:
            begin
                strobe_next = 1'b1;
                if (pend_valid_reg)
                begin
                    res_next.kind            = dstq_pkg::KIND_EXPIRED;
                    res_next.result_id       = pend_reg.id;
                    res_next.result_deadline = pend_reg.deadline;
                end
                else
                begin
                    res_next.kind            = dstq_pkg::KIND_NOTHING;
                    res_next.result_id       = '0;
                    res_next.result_deadline = '0;
                end
                res_next.last   = 1'b1;
                pend_valid_next = 1'b0;
                wr_next         = '0;
            end
            dstq_pkg::CMD_SH_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = wr_reg[AW-1:0];
                wr_next   = wr_reg + CW'(1);
                idx_next  = idx_reg + CW'(1);
            end
            dstq_pkg::CMD_SH_DONE:
            begin
                count_next = wr_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_q <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            map_reg        <= '1;
            idx_reg        <= '0;
            wr_reg         <= '0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            map_reg        <= map_next;
            idx_reg        <= idx_next;
            wr_reg         <= wr_next;
            pend_valid_reg <= pend_valid_next;
            strobe_reg     <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg     <= in_next;
        dl_reg     <= dl_next;
        new_id_reg <= new_id_next;
        pend_reg   <= pend_next;
        res_reg    <= res_next;
    end

    assign result        = res_reg;
    assign result_strobe = strobe_reg;

endmodule

### rtl/core/deadline_sorted_timer_queue.sv
// Top level of the deadline-sorted timer queue: controller plus datapath.
//
// Usage: drive item and raise start; a beat is taken at the clock edge where
// start is high and busy is low. Ops: add (now_time + timeout, saturating,
// gets the lowest free id), remove by target_id, and tick with now_time, which
// emits every timer due at or before now_time in deadline order, equal
// deadlines in arrival order, with last set on the final beat.
// Each result appears on result for exactly one cycle with result_strobe
// high, in the cycle after the step that makes it; the receiver cannot stall.
// Work per op while busy, n pending timers (n at most 16):
//   add     walks from the tail, moving later entries up; full: no walk
//   remove  scans from the head to find the slot, then closes the gap;
//           not found: scans all n entries
//   tick    scans the expired entries from the head, then compacts the
//           table when any expired
// One op at a time: no beat is taken while busy is high. Each step of the
// walk over the single-port table is a registered read followed by a
// compare or a write. Reset empties the queue and frees all ids; the table
// holds no valid data until written and needs no clearing pass.
module deadline_sorted_timer_queue #(
    parameter int QUEUE_DEPTH = dstq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  dstq_pkg::in_t  item,
    output dstq_pkg::out_t result,
    output logic           result_strobe
);

    dstq_pkg::cmd_t    cmd;
    dstq_pkg::status_t status;

    // Sequence the table walk.
    dstq_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Hold the table, id map and result register.
    dstq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item),
        .cmd           (cmd),
        .status        (status),
        .result        (result),
        .result_strobe (result_strobe)
    );

endmodule

### tb/sv/deadline_sorted_timer_queue_tb.sv
// Self-checking regression of the deadline-sorted timer queue.
`timescale 1ns / 100ps

module deadline_sorted_timer_queue_tb;

    // The table is built at its default size, so capacity is the full id space.
    localparam int          TABLE_SLOTS = dstq_pkg::DEFAULT_QUEUE_DEPTH;
    localparam int          CAPACITY    = (TABLE_SLOTS < dstq_pkg::NUM_IDS) ?
                                          TABLE_SLOTS : dstq_pkg::NUM_IDS;
    localparam logic [1:0]  OP_UNUSED   = 2'd3;
    localparam logic [63:0] T_MAX       = '1;
    localparam int          DRAIN_LIMIT = 4000;
    localparam int          SETTLE      = 48;

    logic           clk;
    logic           rst_n;
    logic           start;
    logic           busy;
    dstq_pkg::in_t  item;
    dstq_pkg::out_t result;
    logic           result_strobe;

    deadline_sorted_timer_queue #(
        .QUEUE_DEPTH(TABLE_SLOTS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result       (result),
        .result_strobe(result_strobe)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Predicted queue contents: deadlines in ascending order, ids in step.
    logic [63:0] sorted_deadline [dstq_pkg::NUM_IDS];
    logic [3:0]  sorted_id       [dstq_pkg::NUM_IDS];
    int          live_count;
    logic [15:0] id_free_mask;
    logic [3:0]  last_added_id;

    // Result beats still owed by the queue, oldest first.
    dstq_pkg::out_t timer_outcomes[$];

    bit idle_enabled;
    int mismatch_count;
    int beats_sent;
    int adds_sent;
    int removes_sent;
    int ticks_sent;
    int results_checked;
    int expiries_seen;
    int full_seen;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Random bits in every field; callers overwrite the ones an op uses.
    function automatic dstq_pkg::in_t rand_item();
        dstq_pkg::in_t b;
        b.op        = 2'($urandom_range(0, 3));
        b.now_time  = rand64();
        b.timeout   = $urandom;
        b.target_id = 4'($urandom_range(0, 15));
        return b;
    endfunction

    function automatic dstq_pkg::out_t make_outcome(input logic [2:0] kind,
                                                    input logic [3:0] id,
                                                    input logic [63:0] dl,
                                                    input logic last);
        dstq_pkg::out_t r;
        r.kind            = kind;
        r.result_id       = id;
        r.result_deadline = dl;
        r.last            = last;
        return r;
    endfunction

    // Advance the predicted queue by one accepted beat and queue its results.
    function automatic void apply_timer_op(input dstq_pkg::in_t beat);
        logic [64:0] sum;
        logic [63:0] dl;
        int          pos;
        int          due;
        int          hit;
        logic [3:0]  fid;
        case (beat.op)
            dstq_pkg::OP_ADD:
            begin
                sum = {1'b0, beat.now_time} + {33'd0, beat.timeout};
                dl  = sum[64] ? T_MAX : sum[63:0];
                if (live_count >= CAPACITY || id_free_mask == '0)
                begin
                    timer_outcomes.push_back(make_outcome(dstq_pkg::KIND_FULL, '0, '0, 1'b1));
                end
                else
                begin
                    fid = '0;
                    while (!id_free_mask[fid])
                        fid++;
                    id_free_mask[fid] = 1'b0;
                    // Equal deadlines go behind the ones already queued.
                    pos = 0;
                    while (pos < live_count && !(dl < sorted_deadline[pos]))
                        pos++;
                    for (int i = live_count; i > pos; i--)
                    begin
                        sorted_deadline[i] = sorted_deadline[i-1];
                        sorted_id[i]       = sorted_id[i-1];
                    end
                    sorted_deadline[pos] = dl;
                    sorted_id[pos]       = fid;
                    live_count++;
                    last_added_id = fid;
                    timer_outcomes.push_back(make_outcome(dstq_pkg::KIND_ADDED, fid, dl, 1'b1));
                end
            end
            dstq_pkg::OP_REMOVE:
            begin
                hit = -1;
                for (int i = 0; i < live_count; i++)
                    if (hit < 0 && sorted_id[i] == beat.target_id)
                        hit = i;
                if (hit < 0)
                begin
                    timer_outcomes.push_back(make_outcome(dstq_pkg::KIND_NOT_FOUND,
                                                          beat.target_id, '0, 1'b1));
                end
                else
                begin
                    for (int i = hit; i + 1 < live_count; i++)
                    begin
                        sorted_deadline[i] = sorted_deadline[i+1];
                        sorted_id[i]       = sorted_id[i+1];
                    end
                    live_count--;
                    id_free_mask[beat.target_id] = 1'b1;
                    timer_outcomes.push_back(make_outcome(dstq_pkg::KIND_REMOVED,
                                                          beat.target_id, '0, 1'b1));
                end
            end
            dstq_pkg::OP_TICK:
            begin
                due = 0;
                while (due < live_count && sorted_deadline[due] <= beat.now_time)
                    due++;
                if (due == 0)
                begin
                    timer_outcomes.push_back(make_outcome(dstq_pkg::KIND_NOTHING, '0, '0,
                                                          1'b1));
                end
                else
                begin
                    for (int i = 0; i < due; i++)
                    begin
                        id_free_mask[sorted_id[i]] = 1'b1;
                        timer_outcomes.push_back(make_outcome(dstq_pkg::KIND_EXPIRED,
                                                              sorted_id[i],
                                                              sorted_deadline[i],
                                                              (i + 1 == due)));
                    end
                    for (int i = 0; i + due < live_count; i++)
                    begin
                        sorted_deadline[i] = sorted_deadline[i+due];
                        sorted_id[i]       = sorted_id[i+due];
                    end
                    live_count -= due;
                end
            end
            default:
            begin
                // The spare op code leaves the queue untouched and says nothing.
            end
        endcase
    endfunction

    // Drive one beat and hold it until the queue takes it. Start is left high on
    // return: the next call either keeps it high or drops it for an idle burst,
    // so it never gets two assignments in one step.
    task automatic send_beat(input dstq_pkg::in_t beat);
        if (idle_enabled && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            item  <= rand_item();
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        item  <= beat;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        apply_timer_op(beat);
        beats_sent++;
        case (beat.op)
            dstq_pkg::OP_ADD:    adds_sent++;
            dstq_pkg::OP_REMOVE: removes_sent++;
            dstq_pkg::OP_TICK:   ticks_sent++;
            default:             ;
        endcase
    endtask

    // Fill the fields an op does not use with random bits.
    function automatic dstq_pkg::in_t add_item(input logic [63:0] now,
                                               input logic [31:0] to);
        dstq_pkg::in_t b;
        b          = rand_item();
        b.op       = dstq_pkg::OP_ADD;
        b.now_time = now;
        b.timeout  = to;
        return b;
    endfunction

    function automatic dstq_pkg::in_t remove_item(input logic [3:0] id);
        dstq_pkg::in_t b;
        b           = rand_item();
        b.op        = dstq_pkg::OP_REMOVE;
        b.target_id = id;
        return b;
    endfunction

    function automatic dstq_pkg::in_t tick_item(input logic [63:0] now);
        dstq_pkg::in_t b;
        b          = rand_item();
        b.op       = dstq_pkg::OP_TICK;
        b.now_time = now;
        return b;
    endfunction

    function automatic dstq_pkg::in_t noise_item();
        dstq_pkg::in_t b;
        b    = rand_item();
        b.op = OP_UNUSED;
        return b;
    endfunction

    // Mostly short timeouts so timers expire during the run, some full range.
    function automatic logic [31:0] rand_timeout();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            return $urandom_range(0, 500);
        else if (pick < 9)
            return $urandom;
        else
            return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0;
    endfunction

    function automatic void report_field(input string name, input logic [63:0] want,
                                         input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Results cannot be held off, so take every strobed beat at the edge that
    // ends its cycle and match it against the oldest owed beat.
    always @(posedge clk)
    begin
        dstq_pkg::out_t want;
        if (rst_n && result_strobe)
        begin
            if (timer_outcomes.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none, actual %p",
                         $time, result);
                mismatch_count++;
            end
            else
            begin
                want = timer_outcomes.pop_front();
                report_field("kind", 64'(want.kind), 64'(result.kind));
                report_field("result_id", 64'(want.result_id), 64'(result.result_id));
                report_field("result_deadline", want.result_deadline,
                             result.result_deadline);
                report_field("last", 64'(want.last), 64'(result.last));
                results_checked++;
                if (want.kind == dstq_pkg::KIND_EXPIRED)
                    expiries_seen++;
                if (want.kind == dstq_pkg::KIND_FULL)
                    full_seen++;
            end
        end
    end

    // Empty queue: ticks report nothing, removes report not found.
    task automatic test_empty_queue();
        send_beat(tick_item('0));
        send_beat(tick_item(T_MAX));
        send_beat(remove_item(4'd15));
        send_beat(remove_item(4'd0));
    endtask

    // Deadline arithmetic at both ends, including exact fit and saturation.
    task automatic test_deadline_extremes();
        send_beat(add_item('0, 32'd0));
        send_beat(add_item(T_MAX, 32'hFFFF_FFFF));
        send_beat(add_item(T_MAX - 64'd5, 32'd5));
        send_beat(add_item(T_MAX - 64'd4, 32'd5));
        send_beat(add_item('0, 32'hFFFF_FFFF));
    endtask

    // Same deadline from three routes, removal from the middle of the tie,
    // then expiry exactly at and just below a deadline.
    task automatic test_equal_deadlines();
        logic [3:0] mid_id;
        send_beat(add_item(64'd100, 32'd0));
        send_beat(add_item(64'd50, 32'd50));
        mid_id = last_added_id;
        send_beat(add_item(64'd99, 32'd1));
        send_beat(remove_item(mid_id));
        send_beat(remove_item(mid_id));
        send_beat(tick_item(64'd99));
        send_beat(tick_item(64'd100));
    endtask

    // The spare op code must be dropped; then flush everything that is left,
    // which ends with the three timers at the top deadline in arrival order.
    task automatic test_ignored_op_and_flush();
        send_beat(noise_item());
        send_beat(tick_item(64'h0000_0001_0000_0000));
        send_beat(tick_item(T_MAX - 64'd1));
        send_beat(tick_item(T_MAX));
    endtask

    // Fill every id, overflow it, free one, refill, then expire in two sweeps;
    // the last sweep emits the largest burst the queue can produce.
    task automatic test_fill_to_capacity();
        logic [63:0] base;
        base = rand64() >> 1;
        while (live_count < CAPACITY)
            send_beat(add_item(base, $urandom_range(0, 7) * 10));
        send_beat(add_item(base, rand_timeout()));
        send_beat(add_item(rand64(), rand_timeout()));
        send_beat(remove_item(sorted_id[$urandom_range(0, live_count - 1)]));
        send_beat(add_item(base, 32'd35));
        send_beat(add_item(base, 32'd0));
        send_beat(tick_item(base + 64'd35));
        while (live_count < CAPACITY)
            send_beat(add_item(base + 64'd40, $urandom_range(0, 3)));
        send_beat(tick_item(T_MAX));
    endtask

    // Mixed traffic around a moving clock. Ticks mostly land on or next to a
    // pending deadline, so expiries come in bursts of all sizes.
    task automatic test_random_mix(input int count, input logic [63:0] base);
        logic [63:0] cur_time;
        logic [63:0] pivot;
        int          pick;
        cur_time = base;
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_beat(noise_item());
            cur_time += 64'($urandom_range(0, 300));
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                send_beat(add_item(cur_time, rand_timeout()));
            end
            else if (pick < 70)
            begin
                if (live_count > 0 && $urandom_range(0, 3) != 0)
                    send_beat(remove_item(sorted_id[$urandom_range(0, live_count - 1)]));
                else
                    send_beat(remove_item(4'($urandom_range(0, 15))));
            end
            else
            begin
                pick = $urandom_range(0, 9);
                if (live_count > 0 && pick < 6)
                begin
                    pivot = sorted_deadline[$urandom_range(0, live_count - 1)];
                    case ($urandom_range(0, 2))
                        0:       pivot = pivot - 64'd1;
                        1:       pivot = pivot + 64'd1;
                        default: ;
                    endcase
                end
                else if (pick < 8)
                begin
                    pivot = cur_time;
                end
                else
                begin
                    pivot = rand64();
                end
                send_beat(tick_item(pivot));
            end
        end
    endtask

    initial
    begin
        int waited;
        start          <= 1'b0;
        item           <= '0;
        rst_n          = 1'b0;
        live_count     = 0;
        id_free_mask   = '1;
        last_added_id  = '0;
        idle_enabled   = 1'b1;
        mismatch_count = 0;
        beats_sent     = 0;
        adds_sent      = 0;
        removes_sent   = 0;
        ticks_sent     = 0;
        results_checked = 0;
        expiries_seen  = 0;
        full_seen      = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_queue();
        test_deadline_extremes();
        test_equal_deadlines();
        test_ignored_op_and_flush();

        test_fill_to_capacity();
        test_random_mix(40, '0);
        test_random_mix(30, rand64());
        test_random_mix(10, T_MAX - 64'd20000);
        // Back-to-back traffic to finish: no idle bursts at all.
        idle_enabled = 1'b0;
        test_random_mix(30, rand64() >> 1);

        // Release start and wait for every owed beat, then a quiet stretch to
        // catch any stray result.
        start  <= 1'b0;
        waited = 0;
        while ((timer_outcomes.size() != 0 || busy) && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (timer_outcomes.size() != 0)
        begin
            $display("%0t: missing result beats, expected %0d more, actual 0",
                     $time, timer_outcomes.size());
            mismatch_count++;
        end
        repeat (SETTLE) @(posedge clk);

        $display("Covered %0d beats: %0d adds, %0d removes, %0d ticks, spare op included.",
                 beats_sent, adds_sent, removes_sent, ticks_sent);
        $display("Checked %0d result beats: %0d expiries, %0d full reports, %0d mismatches.",
                 results_checked, expiries_seen, full_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("deadline_sorted_timer_queue regression: pass");
        else
            $display("deadline_sorted_timer_queue regression: fail");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("%0t: watchdog expired", $time);
        $display("deadline_sorted_timer_queue regression: fail");
        $finish;
    end

endmodule
